>>> hw/rtl/bfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared types, constants and the byte-wide crc update for the beacon
// frame checker.
// ----------------------------------------------------------------------------
package bfc_pkg;

   localparam int BYTE_W      = 8;
   localparam int CRC_W       = 16;
   localparam int MAGIC_W     = 32;
   localparam int NODE_ID_W   = 64;
   localparam int COUNTER_W   = 16;
   localparam int RSSI_W      = 16;
   localparam int SNR_W       = 8;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 5;

   localparam int REQ_DATA_W  = BYTE_W + RSSI_W + SNR_W;
   localparam int RSP_DATA_W  = NODE_ID_W + COUNTER_W + RSSI_W + SNR_W;

   localparam logic [MAGIC_W-1:0] MAGIC_RESET = 32'hCAFE_BABE;

   localparam logic [COUNT_W-1:0] FRAME_LEN   = 5'd16;
   localparam logic [COUNT_W-1:0] CRC_SPAN    = 5'd14;
   localparam logic [COUNT_W-1:0] COUNT_SAT   = 5'd17;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_LEN   = 2'd1;
   localparam status_type STATUS_CRC   = 2'd2;
   localparam status_type STATUS_MAGIC = 2'd3;

   // crc-16 xmodem, one byte
   function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] c,
                                                    input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] x;
      logic [CRC_W-1:0]  x16;
      x   = c[15:8] ^ b;
      x   = x ^ (x >> 4);
      x16 = {8'h00, x};
      return {c[7:0], 8'h00} ^ (x16 << 12) ^ (x16 << 5) ^ x16;
   endfunction

endpackage

>>> hw/rtl/beacon_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beacon_frame_checker
// Checks 16-byte beacon frames received one byte per item: length, crc-16
// over the first 14 bytes, then the magic word; one result per last byte.
// ----------------------------------------------------------------------------
// an input register and a result register split the crc and compare logic
// from the ports; a last byte's result is loaded into the result register once
// it is free. throughput: one byte per cycle unless a last byte waits for it
// reset: synchronous, clears the pipeline, byte count and crc, and loads
// magic_word with 0xCAFEBABE
module beacon_frame_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [bfc_pkg::MAGIC_W-1:0]     csr_wr_data,    // magic_word
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bfc_pkg::REQ_DATA_W-1:0]  req_tdata,      // payload_byte, rssi_in, snr_in
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bfc_pkg::RSP_DATA_W-1:0]  rsp_tdata,      // node_id, frame_counter, rssi_out, snr_out
   output logic [bfc_pkg::STATUS_W-1:0]    rsp_tuser       // status
);
   import bfc_pkg::*;

   logic [MAGIC_W-1:0]   magic_word_ff;

   logic                 in_valid_ff;
   logic [BYTE_W-1:0]    in_byte_ff;
   logic                 in_last_ff;
   logic [RSSI_W-1:0]    in_rssi_ff;
   logic [SNR_W-1:0]     in_snr_ff;

   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [CRC_W-1:0]     crc_ff, crc_in;
   logic [MAGIC_W-1:0]   magic_seen_ff, magic_seen_in;
   logic [NODE_ID_W-1:0] node_seen_ff, node_seen_in;
   logic [COUNTER_W-1:0] cnt_seen_ff, cnt_seen_in;
   logic [CRC_W-1:0]     crc_seen_ff, crc_seen_in;

   logic                 rsp_valid_ff;
   status_type           status_ff, status_in;
   logic [NODE_ID_W-1:0] node_out_ff, node_out_in;
   logic [COUNTER_W-1:0] cnt_out_ff, cnt_out_in;
   logic [RSSI_W-1:0]    rssi_out_ff;
   logic [SNR_W-1:0]     snr_out_ff;

   logic out_free;
   logic advance;
   logic emit;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!in_last_ff || out_free);
   assign emit       = advance && in_last_ff;
   assign req_tready = !in_valid_ff || advance;

   // byte position decode, state update and result status
   always_comb begin
      magic_seen_in = magic_seen_ff;
      node_seen_in  = node_seen_ff;
      cnt_seen_in   = cnt_seen_ff;
      crc_seen_in   = crc_seen_ff;
      crc_in        = (count_ff < CRC_SPAN) ? crc_update(crc_ff, in_byte_ff) : crc_ff;
      count_in      = (count_ff < COUNT_SAT) ? count_ff + 5'd1 : count_ff;
      case (count_ff) inside
         [5'd0:5'd3]: begin
            magic_seen_in[count_ff[1:0]*BYTE_W +: BYTE_W] = in_byte_ff;
         end
         [5'd4:5'd11]: begin
            node_seen_in = {node_seen_ff[NODE_ID_W-BYTE_W-1:0], in_byte_ff};
         end
         5'd12: cnt_seen_in[7:0]  = in_byte_ff;
         5'd13: cnt_seen_in[15:8] = in_byte_ff;
         5'd14: crc_seen_in[7:0]  = in_byte_ff;
         5'd15: crc_seen_in[15:8] = in_byte_ff;
         default: ;
      endcase

      node_out_in = '0;
      cnt_out_in  = '0;
      if (count_in != FRAME_LEN) begin
         status_in = STATUS_LEN;
      end else begin
         node_out_in = node_seen_in;
         cnt_out_in  = cnt_seen_in;
         if (crc_in != crc_seen_in) begin
            status_in = STATUS_CRC;
         end else if (magic_seen_in != magic_word_ff) begin
            status_in = STATUS_MAGIC;
         end else begin
            status_in = STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_word_ff <= MAGIC_RESET;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         count_ff      <= '0;
         crc_ff        <= '0;
      end else begin
         if (csr_wr_en) begin
            magic_word_ff <= csr_wr_data;
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            count_ff <= in_last_ff ? '0 : count_in;
            crc_ff   <= in_last_ff ? '0 : crc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_byte_ff <= req_tdata[7:0];
         in_rssi_ff <= req_tdata[23:8];
         in_snr_ff  <= req_tdata[31:24];
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         magic_seen_ff <= magic_seen_in;
         node_seen_ff  <= node_seen_in;
         cnt_seen_ff   <= cnt_seen_in;
         crc_seen_ff   <= crc_seen_in;
      end
      if (emit) begin
         status_ff   <= status_in;
         node_out_ff <= node_out_in;
         cnt_out_ff  <= cnt_out_in;
         rssi_out_ff <= in_rssi_ff;
         snr_out_ff  <= in_snr_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {snr_out_ff, rssi_out_ff, cnt_out_ff, node_out_ff};

endmodule

>>> hw/rtl/bfc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfc_checker
// Port-level checks for the beacon frame checker, bound to the top level.
// ----------------------------------------------------------------------------
module bfc_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tready,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [bfc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic [bfc_pkg::STATUS_W-1:0]    rsp_tuser
);
   import bfc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready right after reset");

   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_LEN |-> rsp_tdata[79:0] == '0)
      else $error("wrong-length item carries node id or counter");

endmodule

bind beacon_frame_checker bfc_checker u_bfc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .rsp_tuser   (rsp_tuser)
);
